@@ hw/rtl/rbeg_pkg.sv @@
// shared types and constants of the rotary button event generator
package rbeg_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_W    = 16;
    localparam int STEP_W   = 6;
    localparam int CODE_W   = 2;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    localparam logic [STEP_W-1:0] MAX_STEPS = 6'd63;
    // first magnitude that is clamped
    localparam logic [WORD_W-1:0] STEP_LIMIT = WORD_W'(MAX_STEPS) + 32'd1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1500;
    localparam logic [CFG_W-1:0] MIN_PRESS_RESET  = 16'd20;

    localparam logic CFG_LONG_PRESS = 1'b0;
    localparam logic CFG_MIN_PRESS  = 1'b1;

    localparam logic [CODE_W-1:0] EV_CW    = 2'd0;
    localparam logic [CODE_W-1:0] EV_CCW   = 2'd1;
    localparam logic [CODE_W-1:0] EV_SHORT = 2'd2;
    localparam logic [CODE_W-1:0] EV_LONG  = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] diff;
        logic              ge;
    } alu_res_t;

endpackage

@@ hw/rtl/rbeg_alu.sv @@
// shared 32 bit subtract and unsigned compare unit
module rbeg_alu
(
    input  logic [rbeg_pkg::WORD_W-1:0] a,
    input  logic [rbeg_pkg::WORD_W-1:0] b,
    output rbeg_pkg::alu_res_t          res
);

    logic [rbeg_pkg::WORD_W:0] sub_full;

    // borrow out clear means a >= b
    assign sub_full = {1'b0, a} - {1'b0, b};
    assign res.diff = sub_full[rbeg_pkg::WORD_W-1:0];
    assign res.ge   = ~sub_full[rbeg_pkg::WORD_W];

endmodule

@@ hw/rtl/rotary_button_event_gen.sv @@
// Rotary encoder and push button event generator. An accepted tick is worked on the
// one shared subtract/compare unit in turn (count
// difference, magnitude, step clamp, elapsed press time, threshold compare),
// then gives one event per cycle while the output side does not stall, and passes a
// closing step: up to 64 events per tick. s_tready is high only while
// no tick is in work. Configuration writes are taken in every cycle.
module rotary_button_event_gen
(
    input  logic                           clk,
    input  logic                           rst_n,
    // tick: encoder_count [31:0], button_level [32], now_ms [64:33], zero fill
    input  logic [rbeg_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // event: event_code [1:0], zero fill
    output logic [rbeg_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [rbeg_pkg::CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_MAG   = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_ELAP  = 3'd4;
    localparam logic [2:0] ST_BTN   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]                        state_reg, state_next;
    logic [rbeg_pkg::CFG_W-1:0]        long_ms_reg, min_ms_reg;
    logic [rbeg_pkg::WORD_W-1:0]       cur_reg, now_reg;
    logic                              btn_reg;
    logic [rbeg_pkg::WORD_W-1:0]       last_count_reg, press_start_reg;
    logic                              last_button_reg, long_fired_reg;
    logic [rbeg_pkg::WORD_W-1:0]       work_reg;
    logic                              neg_reg;
    logic [rbeg_pkg::STEP_W-1:0]       steps_reg;
    logic                              btn_ev_reg;
    logic [rbeg_pkg::CODE_W-1:0]       btn_code_reg;
    logic [rbeg_pkg::CODE_W-1:0]       m_code_reg;
    logic                              m_last_reg, m_valid_reg;
    logic                              m_valid_next;

    logic [rbeg_pkg::WORD_W-1:0]       alu_a, alu_b;
    rbeg_pkg::alu_res_t                alu_res;
    logic                              slot_free;
    logic                              s_hs;

    rbeg_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_hs      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {{(rbeg_pkg::M_DATA_W-rbeg_pkg::CODE_W){1'b0}}, m_code_reg};

    // operand selection for the shared unit
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        unique case (state_reg)
            ST_DIFF:
            begin
                alu_a = cur_reg;
                alu_b = last_count_reg;
            end
            ST_MAG:
            begin
                alu_a = neg_reg ? '0 : work_reg;
                alu_b = neg_reg ? work_reg : '0;
            end
            ST_CLAMP:
            begin
                alu_a = work_reg;
                alu_b = rbeg_pkg::STEP_LIMIT;
            end
            ST_ELAP:
            begin
                alu_a = now_reg;
                alu_b = press_start_reg;
            end
            ST_BTN:
            begin
                // held: elapsed >= long; release: min >= elapsed means too short
                if (!btn_reg && !last_button_reg)
                begin
                    alu_a = work_reg;
                    alu_b = {{(rbeg_pkg::WORD_W-rbeg_pkg::CFG_W){1'b0}}, long_ms_reg};
                end
                else
                begin
                    alu_a = {{(rbeg_pkg::WORD_W-rbeg_pkg::CFG_W){1'b0}}, min_ms_reg};
                    alu_b = work_reg;
                end
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_hs) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MAG;
            ST_MAG:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_ELAP;
            ST_ELAP:  state_next = ST_BTN;
            ST_BTN:   state_next = ST_EMIT;
            ST_EMIT:  if (steps_reg == '0 && !btn_ev_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // output slot: drops on acceptance, loads when an event is pending
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        if (state_reg == ST_EMIT && slot_free && (steps_reg != '0 || btn_ev_reg))
            m_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            long_ms_reg     <= rbeg_pkg::LONG_PRESS_RESET;
            min_ms_reg      <= rbeg_pkg::MIN_PRESS_RESET;
            last_count_reg  <= '0;
            press_start_reg <= '0;
            last_button_reg <= 1'b1;
            long_fired_reg  <= 1'b0;
            steps_reg       <= '0;
            btn_ev_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rbeg_pkg::CFG_LONG_PRESS: long_ms_reg <= cfg_data;
                    rbeg_pkg::CFG_MIN_PRESS:  min_ms_reg  <= cfg_data;
                    default:                  min_ms_reg  <= min_ms_reg;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    steps_reg  <= '0;
                    btn_ev_reg <= 1'b0;
                end
                ST_DIFF:
                begin
                    last_count_reg <= cur_reg;
                end
                ST_CLAMP:
                begin
                    // difference of zero gives zero steps
                    steps_reg <= alu_res.ge ? rbeg_pkg::MAX_STEPS
                                            : work_reg[rbeg_pkg::STEP_W-1:0];
                end
                ST_BTN:
                begin
                    last_button_reg <= btn_reg;
                    if (!btn_reg && last_button_reg)
                    begin
                        press_start_reg <= now_reg;
                        long_fired_reg  <= 1'b0;
                    end
                    else if (!btn_reg && !last_button_reg)
                    begin
                        if (!long_fired_reg && alu_res.ge)
                        begin
                            btn_ev_reg     <= 1'b1;
                            long_fired_reg <= 1'b1;
                        end
                    end
                    else if (btn_reg && !last_button_reg)
                    begin
                        if (!long_fired_reg && !alu_res.ge)
                        begin
                            btn_ev_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        if (steps_reg != '0)
                        begin
                            steps_reg <= steps_reg - 1'b1;
                        end
                        else if (btn_ev_reg)
                        begin
                            btn_ev_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    steps_reg <= steps_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_hs)
        begin
            cur_reg <= s_tdata[rbeg_pkg::WORD_W-1:0];
            btn_reg <= s_tdata[rbeg_pkg::WORD_W];
            now_reg <= s_tdata[2*rbeg_pkg::WORD_W:rbeg_pkg::WORD_W+1];
        end

        unique case (state_reg)
            ST_DIFF:
            begin
                work_reg <= alu_res.diff;
                neg_reg  <= alu_res.diff[rbeg_pkg::WORD_W-1];
            end
            ST_MAG:   work_reg <= alu_res.diff;
            ST_ELAP:  work_reg <= alu_res.diff;
            ST_BTN:   btn_code_reg <= btn_reg ? rbeg_pkg::EV_SHORT : rbeg_pkg::EV_LONG;
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    if (steps_reg != '0)
                    begin
                        m_code_reg <= neg_reg ? rbeg_pkg::EV_CCW : rbeg_pkg::EV_CW;
                        m_last_reg <= (steps_reg == 6'd1) && !btn_ev_reg;
                    end
                    else if (btn_ev_reg)
                    begin
                        m_code_reg <= btn_code_reg;
                        m_last_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
                work_reg <= work_reg;
            end
        endcase
    end

endmodule

@@ sim/rbeg_event_checker.sv @@
`timescale 1ns / 100ps
// event checker: predicts the events of every accepted tick and compares the output stream
module rbeg_event_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    // tick: encoder_count [31:0], button_level [32], now_ms [64:33], zero fill
    input  logic [rbeg_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // event: event_code [1:0], zero fill
    input  logic [rbeg_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [rbeg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           end_of_run,
    output int                             outstanding,
    output int                             fail_count,
    output int                             events_checked,
    output int                             shorts_checked,
    output int                             longs_checked
);

    import rbeg_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } rbeg_event_t;

    rbeg_event_t       expected_events[$];
    logic [WORD_W-1:0] prev_count;
    logic [WORD_W-1:0] press_start;
    logic              prev_button;
    logic              long_fired;
    logic [CFG_W-1:0]  long_ms;
    logic [CFG_W-1:0]  min_ms;
    logic              leftover_checked;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic predict_tick(input logic [WORD_W-1:0] count, input logic btn,
                                input logic [WORD_W-1:0] now);
        logic [WORD_W-1:0] diff;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] held;
        logic [CODE_W-1:0] dir;
        logic [CODE_W-1:0] press_code;
        logic              press_ev;
        int                steps;
        diff = count - prev_count;
        prev_count = count;
        dir = diff[WORD_W-1] ? EV_CCW : EV_CW;
        // a difference of -2^31 stays large after negation
        mag = diff[WORD_W-1] ? -diff : diff;
        if (mag > MAX_STEPS)
            steps = int'(MAX_STEPS);
        else
            steps = int'(mag);
        held = now - press_start;
        press_ev = 1'b0;
        press_code = EV_SHORT;
        if (!btn && prev_button)
        begin
            // press edge only records the start
            press_start = now;
            long_fired = 1'b0;
        end
        else if (!btn && !prev_button)
        begin
            if (!long_fired && held >= long_ms)
            begin
                press_ev = 1'b1;
                press_code = EV_LONG;
                long_fired = 1'b1;
            end
        end
        else if (btn && !prev_button)
        begin
            if (!long_fired && held > min_ms)
                press_ev = 1'b1;
        end
        prev_button = btn;
        for (int i = 0; i < steps; i++)
            expected_events.push_back({dir, (i == steps - 1) && !press_ev});
        if (press_ev)
            expected_events.push_back({press_code, 1'b1});
    endtask

    task automatic check_event(input logic [CODE_W-1:0] code, input logic last);
        rbeg_event_t want;
        events_checked++;
        if (expected_events.size() == 0)
        begin
            report_mismatch($sformatf("event code %0d last %0b with no event expected",
                                      code, last));
            return;
        end
        want = expected_events.pop_front();
        if (code !== want.code)
            report_mismatch($sformatf("event code %0d, expected %0d", code, want.code));
        else if (code == EV_SHORT)
            shorts_checked++;
        else if (code == EV_LONG)
            longs_checked++;
        if (last !== want.last)
            report_mismatch($sformatf("tlast %0b on event code %0d, expected %0b",
                                      last, want.code, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count = '0;
            prev_button = 1'b1;
            press_start = '0;
            long_fired = 1'b0;
            long_ms = LONG_PRESS_RESET;
            min_ms = MIN_PRESS_RESET;
            leftover_checked = 1'b0;
            fail_count = 0;
            events_checked = 0;
            shorts_checked = 0;
            longs_checked = 0;
            expected_events.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_event(m_tdata[CODE_W-1:0], m_tlast);
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[WORD_W-1:0], s_tdata[WORD_W],
                             s_tdata[2*WORD_W:WORD_W+1]);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LONG_PRESS)
                    long_ms = cfg_data;
                else
                    min_ms = cfg_data;
            end
            if (end_of_run && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_events.size() != 0)
                    report_mismatch($sformatf("%0d expected events never arrived",
                                              expected_events.size()));
            end
            outstanding <= expected_events.size();
        end
    end

endmodule

@@ sim/rotary_button_event_gen_tb.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, tick and register stimulus, output stalls and the verdict
module rotary_button_event_gen_tb;

    import rbeg_pkg::*;

    localparam int SETTLE_CYCLES  = 80;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_TICKS   = 28;

    logic                clk;
    logic                rst_n;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                end_of_run;

    int outstanding;
    int fail_count;
    int events_checked;
    int shorts_checked;
    int longs_checked;

    // what the encoder and button look like from the stimulus side
    logic [WORD_W-1:0] enc_count;
    logic [WORD_W-1:0] clock_ms;
    logic [WORD_W-1:0] press_ms;
    logic              btn_level;
    logic [CFG_W-1:0]  long_ms;
    logic [CFG_W-1:0]  min_ms;
    logic              no_idle;
    logic              squeeze_armed;
    logic              squeeze_done;
    int                ticks_sent;
    int                settings_used;
    int                idle_cycles;

    rotary_button_event_gen dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rbeg_event_checker u_event_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .end_of_run     (end_of_run),
        .outstanding    (outstanding),
        .fail_count     (fail_count),
        .events_checked (events_checked),
        .shorts_checked (shorts_checked),
        .longs_checked  (longs_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // leaves tvalid high so a back-to-back tick needs no second assignment
    task automatic send_tick(input logic [WORD_W-1:0] count, input logic btn,
                             input logic [WORD_W-1:0] now);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {{(S_DATA_W-2*WORD_W-1){1'b0}}, now, btn, count};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (!btn && btn_level)
            press_ms = now;
        btn_level = btn;
        enc_count = count;
        clock_ms = now;
        ticks_sent++;
    endtask

    // a tick with no events may still be in work, so settle after the last event
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_thresholds(input logic [CFG_W-1:0] long_val,
                                      input logic [CFG_W-1:0] min_val);
        wait_idle();
        write_reg(CFG_LONG_PRESS, long_val);
        write_reg(CFG_MIN_PRESS, min_val);
        cfg_valid <= 1'b0;
        long_ms = long_val;
        min_ms = min_val;
        settings_used++;
    endtask

    // rotations from single steps to random counts, and press/release sessions timed around the thresholds
    task automatic run_random(input int n_ticks);
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] now;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] step;
        logic              btn;
        int                r;
        span = ((long_ms > min_ms) ? long_ms : min_ms) + 1;
        for (int i = 0; i < n_ticks; i++)
        begin
            count = enc_count;
            btn = btn_level;
            now = clock_ms;
            r = $urandom_range(99);
            step = $urandom_range(4, 1);
            if (r >= 95)
                count = $urandom;
            else if (r >= 40)
            begin
                if (r >= 88)
                    step = $urandom_range(200, 60);
                else if (r >= 75)
                    step = $urandom_range(70, 5);
                count = $urandom_range(1) ? count + step : count - step;
            end
            if ($urandom_range(3) == 0)
                btn = ~btn;
            r = $urandom_range(99);
            if (!btn_level && r < 20)
            begin
                // land on a threshold of the running press, or one ms beside it
                case ($urandom_range(3))
                    0:       now = press_ms + long_ms - 1;
                    1:       now = press_ms + long_ms;
                    2:       now = press_ms + min_ms;
                    default: now = press_ms + min_ms + 1;
                endcase
            end
            else if (r < 85)
                now = now + $urandom_range(span / 3 + 2);
            else if (r < 97)
                now = now + $urandom_range(span * 2, span / 2);
            else
                now = $urandom;
            send_tick(count, btn, now);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LONG_PRESS;
        cfg_data <= '0;
        end_of_run <= 1'b0;
        no_idle = 1'b0;
        squeeze_armed = 1'b0;
        ticks_sent = 0;
        settings_used = 1;
        enc_count = '0;
        clock_ms = '0;
        press_ms = '0;
        btn_level = 1'b1;
        long_ms = LONG_PRESS_RESET;
        min_ms = MIN_PRESS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rotation: single steps, exact and clamped step counts, count wrap
        send_tick(32'h0000_0000, 1'b1, 32'd0);
        send_tick(32'h0000_0001, 1'b1, 32'd10);
        send_tick(32'h0000_0000, 1'b1, 32'd20);
        send_tick(32'h0000_003F, 1'b1, 32'd30);
        send_tick(32'h0000_007F, 1'b1, 32'd40);
        send_tick(32'h8000_007F, 1'b1, 32'd50);
        send_tick(32'h7FFF_FFFF, 1'b1, 32'd60);
        send_tick(32'h8000_0000, 1'b1, 32'd70);
        send_tick(32'hFFFF_FFFF, 1'b1, 32'd90);
        // long press one ms short, then exact, together with rotation
        send_tick(32'hFFFF_FFFF, 1'b0, 32'd1000);
        send_tick(32'hFFFF_FFFF, 1'b0, 32'd2499);
        send_tick(32'h0000_0001, 1'b0, 32'd2500);
        send_tick(32'hFFFF_FFFF, 1'b0, 32'd9000);
        send_tick(32'hFFFF_FFFF, 1'b1, 32'd9001);
        // short press: exactly the minimum, then one more
        send_tick(32'hFFFF_FFFF, 1'b0, 32'd10000);
        send_tick(32'hFFFF_FFFF, 1'b1, 32'd10020);
        send_tick(32'hFFFF_FFFF, 1'b0, 32'd10030);
        send_tick(32'hFFFF_FFFE, 1'b1, 32'd10051);
        // held time across the wrap of the ms clock
        send_tick(32'hFFFF_FFFE, 1'b0, 32'hFFFF_FFF0);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'h0000_05CC);
        send_tick(32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF);

        // zero thresholds: long fires on the first held tick
        program_thresholds(16'd0, 16'd0);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'd100);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'd100);
        send_tick(32'hFFFF_FFFE, 1'b1, 32'd100);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'd200);
        send_tick(32'hFFFF_FFFE, 1'b1, 32'd200);

        // largest thresholds
        program_thresholds(16'hFFFF, 16'hFFFF);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'd0);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'd65535);
        send_tick(32'hFFFF_FFFE, 1'b1, 32'd65600);
        send_tick(32'hFFFF_FFFE, 1'b0, 32'd0);
        send_tick(32'hFFFF_FFFE, 1'b1, 32'd65536);

        program_thresholds(LONG_PRESS_RESET, MIN_PRESS_RESET);
        squeeze_armed = 1'b1;
        run_random(RANDOM_TICKS);
        program_thresholds(16'd0, 16'd0);
        run_random(RANDOM_TICKS);
        program_thresholds(16'hFFFF, 16'hFFFF);
        run_random(RANDOM_TICKS);
        program_thresholds(CFG_W'($urandom_range(3000, 1)), CFG_W'($urandom_range(500)));
        run_random(RANDOM_TICKS);
        program_thresholds(16'd1, 16'hFFFF);
        run_random(RANDOM_TICKS);
        no_idle = 1'b1;
        program_thresholds(16'd30, 16'd5);
        run_random(RANDOM_TICKS);
        no_idle = 1'b0;

        wait_idle();
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);
        $display("%0d ticks under %0d threshold settings, %0d events checked (%0d short, %0d long)",
                 ticks_sent, settings_used, events_checked, shorts_checked, longs_checked);
        $display("count wrap and step clamp, ms wrap, threshold edges, one %0d-cycle output stall",
                 SQUEEZE_CYCLES);
        if (fail_count == 0)
            $display("rotary_button_event_gen test passed");
        else
            $display("rotary_button_event_gen test failed");
        $finish;
    end

    // output side: bursts of ready with random holds, one long hold under load
    initial
    begin
        int burst;
        int gap;
        m_tready <= 1'b0;
        squeeze_done = 1'b0;
        @(posedge clk);
        forever
        begin
            if (squeeze_armed && !squeeze_done)
            begin
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            burst = no_idle ? 32 : $urandom_range(24, 1);
            m_tready <= 1'b1;
            repeat (burst) @(posedge clk);
            gap = no_idle ? 0 : pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transaction", idle_cycles);
            $display("rotary_button_event_gen test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
